// File: rtl/mcg_pkg.sv
`default_nettype none

package mcg_pkg;

  // Fixed widths of the configuration registers and fields.
  localparam int unsigned FPB_W      = 24;
  localparam int unsigned BPB_W      = 5;
  localparam int unsigned BEAT_W     = 4;
  localparam int unsigned CLICK_W    = 16;
  localparam int unsigned STEP_W     = 24;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 3;

  // Defaults of the top-level parameters.
  localparam int unsigned PHASE_BITS_DEF       = 24;
  localparam int unsigned SINE_TABLE_DEPTH_DEF = 256;
  localparam int unsigned SAMPLE_BITS_DEF      = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MUTE            = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_BEAT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEATS_PER_BAR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_LENGTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_PHASE_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_PHASE_STEP  = 3'd5;

  // Register values after reset.
  localparam logic             MUTE_RST   = 1'b1;
  localparam logic [FPB_W-1:0] FPB_RST    = 24'd22050;
  localparam logic [BPB_W-1:0] BPB_RST    = 5'd4;
  localparam logic [CLICK_W-1:0] CLICK_RST = 16'd4096;
  localparam logic [STEP_W-1:0] HIGH_STEP_RST = 24'd334783;
  localparam logic [STEP_W-1:0] LOW_STEP_RST  = 24'd167391;

  // Largest bar the beat index can hold.
  localparam logic [BPB_W-1:0] BPB_MAX = 5'd16;

  typedef struct packed {
    logic               mute;
    logic [FPB_W-1:0]   frames_per_beat;
    logic [BPB_W-1:0]   beats_per_bar;
    logic [CLICK_W-1:0] click_length;
    logic [STEP_W-1:0]  high_phase_step;
    logic [STEP_W-1:0]  low_phase_step;
  } mcg_cfg_t;

endpackage

`default_nettype wire

// File: rtl/mcg_cfg_regs.sv
`default_nettype none

module mcg_cfg_regs
  import mcg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output mcg_cfg_t                   cfg
);

  mcg_cfg_t cfg_r;

  // Register file; writes to unlisted indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mute            <= MUTE_RST;
      cfg_r.frames_per_beat <= FPB_RST;
      cfg_r.beats_per_bar   <= BPB_RST;
      cfg_r.click_length    <= CLICK_RST;
      cfg_r.high_phase_step <= HIGH_STEP_RST;
      cfg_r.low_phase_step  <= LOW_STEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MUTE:            cfg_r.mute            <= cfg_data[0];
        REG_FRAMES_PER_BEAT: cfg_r.frames_per_beat <= cfg_data[FPB_W-1:0];
        REG_BEATS_PER_BAR:   cfg_r.beats_per_bar   <= cfg_data[BPB_W-1:0];
        REG_CLICK_LENGTH:    cfg_r.click_length    <= cfg_data[CLICK_W-1:0];
        REG_HIGH_PHASE_STEP: cfg_r.high_phase_step <= cfg_data[STEP_W-1:0];
        REG_LOW_PHASE_STEP:  cfg_r.low_phase_step  <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/mcg_sine.sv
`default_nettype none

module mcg_sine
  import mcg_pkg::*;
#(
  parameter int unsigned PHASE_BITS       = PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
  input  wire logic [PHASE_BITS-1:0]  phase,
  output logic      [SAMPLE_BITS-1:0] sample
);

  localparam int unsigned REST_W = PHASE_BITS - 2;
  localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned PROD_W = REST_W + IDX_W + 1;
  localparam int unsigned MAG_W  = SAMPLE_BITS - 1;

  // Fixed denominators and scale of the table entries.
  localparam logic [63:0] X_DEN  = 64'(2 * SINE_TABLE_DEPTH);
  localparam logic [63:0] Q_DEN  = 64'd10 << 30;
  localparam logic [63:0] Q_HALF = 64'd5 << 30;
  localparam logic [63:0] SCALE  = (64'd1 << (SAMPLE_BITS - 1)) * 64'd7;

  // One quarter-wave entry, sampled at the middle of its slot. The sine is a
  // Q30 Taylor series to x^11 in Horner form with truncating shifts, scaled
  // to 0.7 full scale and rounded. Evaluated only at elaboration.
  function automatic logic [MAG_W-1:0] sine_entry(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    x  = (64'(2 * i + 1) * 64'd1686629713) / X_DEN;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd110);
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd72);
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd42);
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd20);
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    q  = (s * SCALE + Q_HALF) / Q_DEN;
    return q[MAG_W-1:0];
  endfunction

  // Constant quarter-wave table.
  logic [MAG_W-1:0] rom [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [MAG_W-1:0] ENTRY = sine_entry(g);
    assign rom[g] = ENTRY;
  end

  logic [1:0]        quad;
  logic [REST_W-1:0] rest;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_m;
  logic [SAMPLE_BITS-1:0] mag;

  // Quadrant split, index scaling, mirroring and sign.
  always_comb begin
    quad  = phase[PHASE_BITS-1 -: 2];
    rest  = phase[REST_W-1:0];
    prod  = PROD_W'(rest) * PROD_W'(SINE_TABLE_DEPTH);
    idx   = prod[REST_W +: IDX_W];
    idx_m = quad[0] ? (IDX_W'(SINE_TABLE_DEPTH - 1) - idx) : idx;
    mag   = {1'b0, rom[idx_m]};
    sample = quad[1] ? (SAMPLE_BITS'(0) - mag) : mag;
  end

endmodule

`default_nettype wire

// File: rtl/metronome_click_generator_unit.sv
// Channel | Dir | Payload ports                                       | Handshake
// input   | in  | in_restart                                          | in_valid / in_ready
// result  | out | out_click_sample, out_click_active, out_beat_number | out_valid / out_ready
// config  | in  | cfg_index, cfg_data                                 | cfg_wr_en, no wait
//
// One transaction is accepted per cycle unless a stalled result fills the input register;
// its result is presented from the result register. The input register feeds one pass of
// counter, click and sine-table logic into the result register; the table lookup sets the longest path.
// Reset is synchronous: counters, click state, valid flags and config registers return to defaults.
// A stalled result holds; the input register still takes one more transaction.
`default_nettype none

module metronome_click_generator_unit
  import mcg_pkg::*;
#(
  parameter int unsigned PHASE_BITS       = PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_restart,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_click_sample,
  output logic                        out_click_active,
  output logic      [BEAT_W-1:0]      out_beat_number,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  mcg_cfg_t cfg;

  mcg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipeline control.
  logic s1_valid_r;
  logic s1_restart_r;
  logic out_valid_r;
  logic adv;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  // Position and click state.
  logic [FPB_W-1:0]      fib_r,   fib_nxt;
  logic [BEAT_W-1:0]     beat_r,  beat_nxt;
  logic                  lbv_r,   lbv_nxt;
  logic [CLICK_W-1:0]    rem_r,   rem_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic                  hi_r,    hi_nxt;

  // Result payload.
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic                   active_r, active_nxt;
  logic [BEAT_W-1:0]      bnum_r,   bnum_nxt;

  logic [SAMPLE_BITS-1:0] sine_val;
  logic [PHASE_BITS-1:0]  phase_cur;

  mcg_sine #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_sine (
    .phase  (phase_cur),
    .sample (sine_val)
  );

  logic [FPB_W-1:0]      fib0;
  logic [BEAT_W-1:0]     beat0;
  logic                  lbv0;
  logic [CLICK_W-1:0]    rem1;
  logic                  hi1;
  logic [FPB_W-1:0]      fpb_eff;
  logic [BPB_W-1:0]      bpb_eff;
  logic [FPB_W:0]        fib_inc;
  logic [BPB_W-1:0]      beat_inc;
  logic                  wrap;
  logic [BEAT_W-1:0]     beat_adv;
  logic [PHASE_BITS-1:0] step;

  // One sample of the metronome: restart, click start, tone, position; mute holds the state and gives zero.
  always_comb begin
    fib0  = s1_restart_r ? '0 : fib_r;
    beat0 = s1_restart_r ? '0 : beat_r;
    lbv0  = s1_restart_r ? 1'b0 : lbv_r;

    fpb_eff = (cfg.frames_per_beat == '0) ? FPB_W'(1) : cfg.frames_per_beat;
    if (cfg.beats_per_bar == '0) begin
      bpb_eff = BPB_W'(1);
    end else if (cfg.beats_per_bar > BPB_MAX) begin
      bpb_eff = BPB_MAX;
    end else begin
      bpb_eff = cfg.beats_per_bar;
    end

    // A new click starts when the current beat has not yet sounded.
    rem1      = lbv0 ? rem_r : cfg.click_length;
    phase_cur = lbv0 ? phase_r : '0;
    hi1       = lbv0 ? hi_r : (beat0 == '0);
    step      = hi1 ? PHASE_BITS'(cfg.high_phase_step) : PHASE_BITS'(cfg.low_phase_step);

    // Frame and beat advance.
    fib_inc  = {1'b0, fib0} + (FPB_W+1)'(1);
    wrap     = fib_inc >= {1'b0, fpb_eff};
    beat_inc = {1'b0, beat0} + BPB_W'(1);
    beat_adv = (beat_inc >= bpb_eff) ? '0 : beat_inc[BEAT_W-1:0];

    bnum_nxt = beat0;
    if (cfg.mute) begin
      fib_nxt    = fib0;
      beat_nxt   = beat0;
      lbv_nxt    = lbv0;
      rem_nxt    = rem_r;
      phase_nxt  = phase_r;
      hi_nxt     = hi_r;
      sample_nxt = '0;
      active_nxt = 1'b0;
    end else begin
      hi_nxt     = hi1;
      active_nxt = (rem1 != '0);
      sample_nxt = active_nxt ? sine_val : '0;
      phase_nxt  = active_nxt ? (phase_cur + step) : phase_cur;
      rem_nxt    = active_nxt ? (rem1 - CLICK_W'(1)) : rem1;
      fib_nxt    = wrap ? '0 : fib_inc[FPB_W-1:0];
      beat_nxt   = wrap ? beat_adv : beat0;
      lbv_nxt    = !(wrap && (beat_adv != beat0));
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fib_r       <= '0;
      beat_r      <= '0;
      lbv_r       <= 1'b0;
      rem_r       <= '0;
      phase_r     <= '0;
      hi_r        <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        fib_r       <= fib_nxt;
        beat_r      <= beat_nxt;
        lbv_r       <= lbv_nxt;
        rem_r       <= rem_nxt;
        phase_r     <= phase_nxt;
        hi_r        <= hi_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_restart_r <= in_restart;
    end
    if (adv) begin
      sample_r <= sample_nxt;
      active_r <= active_nxt;
      bnum_r   <= bnum_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_click_sample = sample_r;
  assign out_click_active = active_r;
  assign out_beat_number  = bnum_r;

endmodule

`default_nettype wire

// File: rtl/mcg_checker.sv
`default_nettype none

module mcg_checker
  import mcg_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [SAMPLE_BITS-1:0] out_click_sample,
  input wire logic                   out_click_active,
  input wire logic [BEAT_W-1:0]      out_beat_number
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_click_sample)
      && $stable(out_click_active) && $stable(out_beat_number))
    else $error("result changed while stalled");

  // Silence is exact zero.
  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_click_active |-> out_click_sample == '0)
    else $error("non-zero sample without an active click");

  // Nothing is presented straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A result needs an accepted input that has passed through the input register.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(!in_ready, 1))
    else $error("result without an input transaction");

endmodule

bind metronome_click_generator_unit mcg_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mcg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_click_sample (out_click_sample),
  .out_click_active (out_click_active),
  .out_beat_number  (out_beat_number)
);

`default_nettype wire
